### sv/tdq_pkg.sv
// Shared types and constants for the deadline timer queue.
package tdq_pkg;

    localparam int ID_W        = 8;
    localparam int TIMEOUT_W   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

    // Input command codes
    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_TICK     = 1'b1;

    // Result status codes
    localparam logic STATUS_FIRED  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // One result word
    typedef struct packed {
        logic [ID_W-1:0] fired_id;
        logic            status;
        logic            last;
    } res_word_t;

endpackage

### sv/tdq_mem.sv
// Entry table: simple dual-port synchronous RAM with a registered read port.
module tdq_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 40
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/tdq_obuf.sv
// Output register stage for result words.
module tdq_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  tdq_pkg::res_word_t in_word,
    output logic               m_valid,
    input  logic               m_ready,
    output tdq_pkg::res_word_t out_word
);

    logic               valid_reg;
    logic               valid_next;
    tdq_pkg::res_word_t word_reg;

    // free when empty or being drained this cycle
    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= in_word;
        end
    end

    assign m_valid  = valid_reg;
    assign out_word = word_reg;

endmodule

### sv/deadline_timer_queue_core.sv
// Schedule: written directly into an empty table, appended at the tail after scanning every entry,
//   else scanned, the tail shifted up and the entry placed via the single RAM ports; full: reject.
// Tick: advances time, then one table read per examined entry, one per cycle;
//   fired words leave one per cycle, each held until the next due entry or the flush;
//   output stalls hold the scan.
// Reset (aresetn, synchronous, active low) clears time, head, fill count and control only.
module deadline_timer_queue_core #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_cmd,
    input  logic [tdq_pkg::ID_W-1:0]      s_task_id,
    input  logic [tdq_pkg::TIMEOUT_W-1:0] s_timeout,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tdq_pkg::ID_W-1:0]      m_fired_id,
    output logic                         m_status,
    output logic                         m_last
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int ENT_W = TIME_BITS + tdq_pkg::ID_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_SHIFT = 6'b000100,
        ST_PLACE = 6'b001000,
        ST_TCHK  = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [TIME_BITS-1:0]            now_reg, now_next;
    logic [IDX_W-1:0]                head_reg, head_next;
    logic [CNT_W-1:0]                count_reg, count_next;
    logic [CNT_W-1:0]                k_reg, k_next;
    logic [CNT_W-1:0]                pos_reg, pos_next;
    logic [tdq_pkg::ID_W-1:0]        id_reg, id_next;
    logic [tdq_pkg::TIMEOUT_W-1:0]   timeout_reg, timeout_next;
    logic [TIME_BITS-1:0]            dl_reg, dl_next;
    logic [tdq_pkg::FIRE_W-1:0]      fired_reg, fired_next;
    logic                            hold_valid_reg, hold_valid_next;
    logic [tdq_pkg::ID_W-1:0]        hold_id_reg, hold_id_next;
    logic                            hold_status_reg, hold_status_next;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [ENT_W-1:0]                mem_wdata;
    logic                            mem_re;
    logic [IDX_W-1:0]                mem_raddr;
    logic [ENT_W-1:0]                mem_rdata;

    logic                            push_valid;
    logic                            push_ready;
    tdq_pkg::res_word_t              push_word;
    tdq_pkg::res_word_t              out_word;

    logic [TIME_BITS-1:0]            rd_deadline;
    logic [tdq_pkg::ID_W-1:0]        rd_handle;
    logic [TIME_BITS-1:0]            diff;
    logic                            go_after;
    logic                            due;
    logic [TIME_BITS-1:0]            new_dl;

    // logical offset from head to RAM address, wrapping at TABLE_DEPTH
    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(TABLE_DEPTH)) begin
            sum = sum - SUM_W'(TABLE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    tdq_mem #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (ENT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    tdq_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_word  (push_word),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .out_word (out_word)
    );

    assign m_fired_id = out_word.fired_id;
    assign m_status   = out_word.status;
    assign m_last     = out_word.last;

    // compare read entry against current time
    assign rd_deadline = mem_rdata[ENT_W-1:tdq_pkg::ID_W];
    assign rd_handle   = mem_rdata[tdq_pkg::ID_W-1:0];
    assign diff        = rd_deadline - now_reg;
    assign go_after    = diff[TIME_BITS-1] || (diff <= TIME_BITS'(timeout_reg));
    assign due         = (diff == '0) || diff[TIME_BITS-1];
    assign new_dl      = now_reg + TIME_BITS'(s_timeout);

    assign s_ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next       = state_reg;
        now_next         = now_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        k_next           = k_reg;
        pos_next         = pos_reg;
        id_next          = id_reg;
        timeout_next     = timeout_reg;
        dl_next          = dl_reg;
        fired_next       = fired_reg;
        hold_valid_next  = hold_valid_reg;
        hold_id_next     = hold_id_reg;
        hold_status_next = hold_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = head_reg;
        mem_wdata        = {dl_reg, id_reg};
        mem_re           = 1'b0;
        mem_raddr        = head_reg;
        push_valid       = 1'b0;
        push_word        = '{fired_id: hold_id_reg, status: hold_status_reg, last: 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == tdq_pkg::CMD_TICK) begin
                        now_next = now_reg + TIME_BITS'(1);
                        if (count_reg != '0) begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg;
                            fired_next = '0;
                            state_next = ST_TCHK;
                        end
                    end else if (count_reg == CNT_W'(TABLE_DEPTH)) begin
                        // table full: reject
                        hold_valid_next  = 1'b1;
                        hold_id_next     = s_task_id;
                        hold_status_next = tdq_pkg::STATUS_REJECT;
                        state_next       = ST_FLUSH;
                    end else if (count_reg == '0) begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_reg;
                        mem_wdata  = {new_dl, s_task_id};
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        id_next      = s_task_id;
                        timeout_next = s_timeout;
                        dl_next      = new_dl;
                        k_next       = '0;
                        mem_re       = 1'b1;
                        mem_raddr    = head_reg;
                        state_next   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (go_after) begin
                    if (k_reg + CNT_W'(1) == count_reg) begin
                        // goes behind every entry: append
                        mem_we     = 1'b1;
                        mem_waddr  = phys_idx(head_reg, count_reg);
                        count_next = count_reg + CNT_W'(1);
                        state_next = ST_IDLE;
                    end else begin
                        k_next    = k_reg + CNT_W'(1);
                        mem_re    = 1'b1;
                        mem_raddr = phys_idx(head_reg, k_reg + CNT_W'(1));
                    end
                end else begin
                    // insertion point found; shift tail up from the back
                    pos_next   = k_reg;
                    k_next     = count_reg;
                    mem_re     = 1'b1;
                    mem_raddr  = phys_idx(head_reg, count_reg - CNT_W'(1));
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                mem_we    = 1'b1;
                mem_waddr = phys_idx(head_reg, k_reg);
                mem_wdata = mem_rdata;
                if (k_reg - CNT_W'(1) == pos_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = phys_idx(head_reg, k_reg - CNT_W'(2));
                    k_next    = k_reg - CNT_W'(1);
                end
            end
            ST_PLACE: begin
                mem_we     = 1'b1;
                mem_waddr  = phys_idx(head_reg, pos_reg);
                count_next = count_reg + CNT_W'(1);
                state_next = ST_IDLE;
            end
            ST_TCHK: begin
                if (due) begin
                    // previous held word is not last; stall until it can leave
                    if (!hold_valid_reg || push_ready) begin
                        push_valid       = hold_valid_reg;
                        hold_valid_next  = 1'b1;
                        hold_id_next     = rd_handle;
                        hold_status_next = tdq_pkg::STATUS_FIRED;
                        head_next        = phys_idx(head_reg, CNT_W'(1));
                        count_next       = count_reg - CNT_W'(1);
                        fired_next       = fired_reg + tdq_pkg::FIRE_W'(1);
                        if (count_reg == CNT_W'(1) ||
                            fired_reg + tdq_pkg::FIRE_W'(1) ==
                            tdq_pkg::FIRE_W'(tdq_pkg::MAX_RESULTS)) begin
                            state_next = ST_FLUSH;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = phys_idx(head_reg, CNT_W'(1));
                        end
                    end
                end else if (hold_valid_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                push_valid     = 1'b1;
                push_word.last = 1'b1;
                if (push_ready) begin
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        k_reg           <= k_next;
        pos_reg         <= pos_next;
        id_reg          <= id_next;
        timeout_reg     <= timeout_next;
        dl_reg          <= dl_next;
        fired_reg       <= fired_next;
        hold_id_reg     <= hold_id_next;
        hold_status_reg <= hold_status_next;
    end

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_flush_has_word: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FLUSH |-> hold_valid_reg)
        else $error("flush without a held word");

    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == tdq_pkg::CMD_SCHEDULE &&
         count_reg == CNT_W'(TABLE_DEPTH))
        |=> (state_reg == ST_FLUSH && hold_status_reg == tdq_pkg::STATUS_REJECT))
        else $error("full-table schedule not rejected");

    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_TCHK |->
        fired_reg < tdq_pkg::FIRE_W'(tdq_pkg::MAX_RESULTS))
        else $error("tick examined past the result limit");

    a_shift_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT |-> k_reg > pos_reg)
        else $error("shift index below insertion point");

endmodule

### test/deadline_timer_queue_core_test.sv
// Self-checking testbench for deadline_timer_queue_core with a built-in timer queue predictor.
`timescale 1ns / 1ps

module deadline_timer_queue_core_test;

    localparam int TABLE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    // An insertion at the front of a nearly full table ends far sooner than STALL_LIMIT quiet
    // cycles, so reaching that limit means a hang
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 100;

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_cmd;
    logic [tdq_pkg::ID_W-1:0]      s_task_id;
    logic [tdq_pkg::TIMEOUT_W-1:0] s_timeout;
    logic                          m_valid;
    logic                          m_ready;
    logic [tdq_pkg::ID_W-1:0]      m_fired_id;
    logic                          m_status;
    logic                          m_last;

    // Predicted timer table: pending handles in firing order
    logic [TIME_BITS-1:0]     tick_now;
    logic [TIME_BITS-1:0]     pend_deadline [TABLE_DEPTH];
    logic [tdq_pkg::ID_W-1:0] pend_handle [TABLE_DEPTH];
    int                       pend_count;

    tdq_pkg::res_word_t due_words [$];
    int                 mismatch_count;
    int                 words_sent;
    int                 stall_cycles;
    bit                 no_gaps;

    deadline_timer_queue_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cmd      (s_cmd),
        .s_task_id  (s_task_id),
        .s_timeout  (s_timeout),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_fired_id (m_fired_id),
        .m_status   (m_status),
        .m_last     (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        mismatch_count++;
    endtask

    // Apply one accepted word to the predicted table and queue the result words it produces
    task automatic predict_timer_queue(input logic cmd, input logic [tdq_pkg::ID_W-1:0] id,
                                       input logic [tdq_pkg::TIMEOUT_W-1:0] tmo);
        logic [TIME_BITS-1:0] rem;
        logic [TIME_BITS-1:0] tmo_ext;
        tdq_pkg::res_word_t   w;
        int                   pos;
        int                   fired;
        bit                   scanning;
        tmo_ext = tmo;
        if (cmd == tdq_pkg::CMD_SCHEDULE) begin
            if (pend_count >= TABLE_DEPTH) begin
                w.fired_id = id;
                w.status   = tdq_pkg::STATUS_REJECT;
                w.last     = 1'b1;
                due_words.push_back(w);
            end else begin
                // Go after every entry due no later than the new one
                pos = 0;
                scanning = 1'b1;
                while (scanning && pos < pend_count) begin
                    rem = pend_deadline[pos] - tick_now;
                    if (rem[TIME_BITS-1] || rem <= tmo_ext) pos++;
                    else scanning = 1'b0;
                end
                for (int k = pend_count; k > pos; k--) begin
                    pend_deadline[k] = pend_deadline[k-1];
                    pend_handle[k]   = pend_handle[k-1];
                end
                pend_deadline[pos] = tick_now + tmo_ext;
                pend_handle[pos]   = id;
                pend_count++;
            end
        end else begin
            tick_now = tick_now + 1'b1;
            // Count the due entries at the front, wrap-safe compare
            fired = 0;
            scanning = 1'b1;
            while (scanning && fired < pend_count && fired < tdq_pkg::MAX_RESULTS) begin
                rem = pend_deadline[fired] - tick_now;
                if (rem == '0 || rem[TIME_BITS-1]) fired++;
                else scanning = 1'b0;
            end
            for (int k = 0; k < fired; k++) begin
                w.fired_id = pend_handle[k];
                w.status   = tdq_pkg::STATUS_FIRED;
                w.last     = (k == fired - 1);
                due_words.push_back(w);
            end
            for (int k = 0; k + fired < pend_count; k++) begin
                pend_deadline[k] = pend_deadline[k+fired];
                pend_handle[k]   = pend_handle[k+fired];
            end
            pend_count -= fired;
        end
    endtask

    // Drive one word, idling at random beforehand, and hold it until accepted
    task automatic send_word(input logic cmd, input logic [tdq_pkg::ID_W-1:0] id,
                             input logic [tdq_pkg::TIMEOUT_W-1:0] tmo);
        while (!no_gaps && $urandom_range(99) < 13) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= cmd;
        s_task_id <= id;
        s_timeout <= tmo;
        do @(posedge aclk); while (!s_ready);
        predict_timer_queue(cmd, id, tmo);
        words_sent++;
    endtask

    task automatic send_tick();
        send_word(tdq_pkg::CMD_TICK, 8'($urandom), 16'($urandom));
    endtask

    // Hold the sender off until every predicted word has come back
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_words.size() != 0);
    endtask

    task automatic test_tick_on_empty();
        send_tick();
        send_tick();
    endtask

    // Fill the table with mixed zero and one-tick timeouts, overflow it, then fire all at once
    task automatic test_full_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_word(tdq_pkg::CMD_SCHEDULE, 8'(i * 17), (i % 3 == 0) ? 16'd1 : 16'd0);
        send_word(tdq_pkg::CMD_SCHEDULE, 8'h5A, 16'd0);
        send_word(tdq_pkg::CMD_SCHEDULE, 8'hA5, 16'hFFFF);
        send_tick();
        wait_results_drained();
    endtask

    // Far deadlines stay pending for the rest of the run; new entries insert ahead of them
    task automatic test_long_timeouts();
        send_word(tdq_pkg::CMD_SCHEDULE, 8'hC3, 16'hFFFF);
        send_word(tdq_pkg::CMD_SCHEDULE, 8'h3C, 16'h8000);
        send_word(tdq_pkg::CMD_SCHEDULE, 8'h81, 16'd2);
        send_word(tdq_pkg::CMD_SCHEDULE, 8'h7E, 16'd2);
        send_tick();
        send_tick();
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int start;
        int seg;
        int mode;
        int pick;
        start = words_sent;
        seg = 0;
        while (words_sent - start < 360) begin
            no_gaps = (seg == 4 || seg == 5);
            pick = $urandom_range(5);
            mode = (pick < 3) ? 0 : (pick < 5) ? 1 : 2;
            case (mode)
                0: begin
                    // Mixed schedules and ticks, mostly short timeouts
                    for (int i = 0; i < 24; i++) begin
                        if ($urandom_range(1) == 0) begin
                            send_tick();
                        end else begin
                            pick = $urandom_range(99);
                            send_word(tdq_pkg::CMD_SCHEDULE, 8'($urandom),
                                      (pick < 70) ? 16'($urandom_range(16)) :
                                      (pick < 95) ? 16'($urandom_range(64)) :
                                                    16'($urandom_range(255)));
                        end
                    end
                end
                1: begin
                    // Burst of near deadlines that overflows the table, then fire
                    for (int i = 0; i < 18; i++)
                        send_word(tdq_pkg::CMD_SCHEDULE, 8'($urandom),
                                  16'($urandom_range(6)));
                    for (int i = 0; i < 8; i++)
                        send_tick();
                end
                default: begin
                    for (int i = 0; i < 10; i++)
                        send_tick();
                end
            endcase
            if ($urandom_range(2) == 0) wait_results_drained();
            seg++;
        end
        no_gaps = 1'b0;
    endtask

    // Result side: random back-pressure
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 13);
    end

    // Compare each accepted word with the oldest prediction
    always @(posedge aclk) begin : check_words
        tdq_pkg::res_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (due_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word id=%0h status=%0b last=%0b",
                                          m_fired_id, m_status, m_last));
            end else begin
                want = due_words.pop_front();
                if (m_fired_id !== want.fired_id)
                    report_mismatch($sformatf("fired_id %0h, expected %0h",
                                              m_fired_id, want.fired_id));
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0b, expected %0b for id %0h",
                                              m_status, want.status, want.fired_id));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b for id %0h",
                                              m_last, want.last, want.fired_id));
            end
        end
    end

    // Count cycles in which neither channel moves a word
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("deadline_timer_queue_core regression: fail");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_cmd     <= tdq_pkg::CMD_SCHEDULE;
        s_task_id <= '0;
        s_timeout <= '0;
        m_ready   <= 1'b0;
        tick_now       = '0;
        pend_count     = 0;
        mismatch_count = 0;
        words_sent     = 0;
        stall_cycles   = 0;
        no_gaps        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_tick_on_empty();
        test_full_table();
        test_long_timeouts();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (due_words.size() != 0)
            report_mismatch($sformatf("%0d predicted words never arrived", due_words.size()));
        if (mismatch_count == 0) begin
            $display("deadline_timer_queue_core regression: pass");
        end else begin
            $display("deadline_timer_queue_core regression: fail");
        end
        $finish;
    end

endmodule
